/* src/jhv_pkg.sv */
// Package for the joystick heading vector unit: sizes, configuration register
// indexes, the configuration struct and the quarter-wave sine table.
// No dependencies.
`timescale 1ns / 1ps

package jhv_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QTR_SIZE = 1 << SINE_TABLE_BITS;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] REG_AXIS_MID = 2'd0;
  localparam logic [1:0] REG_STEP_SCALE = 2'd1;
  localparam logic [1:0] REG_FILTER_THRESHOLD = 2'd2;

  typedef struct packed {
    logic [15:0]        axis_mid;
    logic signed [31:0] step_scale;
    logic [15:0]        filter_threshold;
  } cfg_t;

  typedef logic [14:0] sin_tab_t [QTR_SIZE + 1];

  function automatic logic [14:0] sine_entry(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] r;
    x = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum = sum - $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    r = ($unsigned(sum) + 64'd32768) >> 16;
    if (r > 64'd16384) begin
      r = 64'd16384;
    end
    return r[14:0];
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    for (int k = 0; k <= QTR_SIZE; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

/* src/jhv_sample_if.sv */
// Input channel of the joystick heading vector unit: one raw axis sample.
// No dependencies.
`timescale 1ns / 1ps

interface jhv_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] axis_sample;

  modport source(output valid, output axis_sample, input ready);
  modport sink(input valid, input axis_sample, output ready);
endinterface

/* src/jhv_heading_if.sv */
// Output channel of the joystick heading vector unit: the held Q1.14 vector
// and its change flag. No dependencies.
`timescale 1ns / 1ps

interface jhv_heading_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] heading_x;
  logic signed [15:0] heading_y;
  logic               vector_changed;

  modport source(output valid, output heading_x, output heading_y,
                 output vector_changed, input ready);
  modport sink(input valid, input heading_x, input heading_y,
               input vector_changed, output ready);
endinterface

/* src/jhv_front.sv */
// Front end: accepts samples, removes the midpoint and scales them into a
// registered phase increment. Depends on jhv_pkg and jhv_sample_if.
`timescale 1ns / 1ps

module jhv_front
  import jhv_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  jhv_sample_if.sink     sample,
  input  cfg_t           cfg,
  output logic           push_valid,
  input  logic           push_ready,
  output logic [15:0]    push_inc
);

  logic signed [SAMPLE_BITS:0]    diff;
  logic signed [SAMPLE_BITS+32:0] product;
  logic                           f_valid;
  logic [15:0]                    f_inc;
  logic                           accept;

  assign diff = $signed({1'b0, sample.axis_sample[SAMPLE_BITS-1:0]})
              - $signed({1'b0, cfg.axis_mid[SAMPLE_BITS-1:0]});
  assign product = (SAMPLE_BITS + 33)'(diff) * (SAMPLE_BITS + 33)'($signed(cfg.step_scale));

  assign sample.ready = !f_valid || push_ready;
  assign accept = sample.valid && sample.ready;
  assign push_valid = f_valid;
  assign push_inc = f_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push_ready) begin
      f_valid <= 1'b0;
    end
    if (accept) begin
      f_inc <= product[31:16];
    end
  end

endmodule

/* src/jhv_queue.sv */
// Short queue of phase increments between the front and back ends.
// Depends on jhv_pkg for the depth.
`timescale 1ns / 1ps

module jhv_queue
  import jhv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  logic [15:0] push_inc,
  output logic        pop_valid,
  input  logic        pop_ready,
  output logic [15:0] pop_inc
);

  logic [15:0]          entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = count != (QPTR_BITS + 1)'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_inc = entries[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= push_inc;
    end
  end

endmodule

/* src/jhv_back.sv */
// Back end: accumulates the heading phase, looks up cosine and sine and
// applies the change filter to the held vector. Depends on jhv_pkg and
// jhv_heading_if.
`timescale 1ns / 1ps

module jhv_back
  import jhv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  logic [15:0] pop_inc,
  jhv_heading_if.source heading
);

  logic [15:0]              phase;
  logic                     a_valid;
  logic                     b_valid;
  logic [1:0]               b_quad;
  logic [14:0]              b_lo;
  logic [14:0]              b_hi;
  logic                     out_valid;
  logic signed [15:0]       held_x;
  logic signed [15:0]       held_y;
  logic                     changed;
  logic                     a_ready;
  logic                     b_ready;
  logic                     c_ready;
  logic [SINE_TABLE_BITS-1:0] idx_lo;
  logic [SINE_TABLE_BITS:0]   idx_hi;
  logic signed [15:0]       cs;
  logic signed [15:0]       sn;
  logic signed [16:0]       dx;
  logic signed [16:0]       dy;
  logic [16:0]              adx;
  logic [16:0]              ady;
  logic signed [15:0]       nx;
  logic signed [15:0]       ny;

  assign c_ready = !out_valid || heading.ready;
  assign b_ready = !b_valid || c_ready;
  assign a_ready = !a_valid || b_ready;
  assign pop_ready = a_ready;

  assign idx_lo = phase[13 -: SINE_TABLE_BITS];
  assign idx_hi = (SINE_TABLE_BITS + 1)'(QTR_SIZE) - {1'b0, idx_lo};

  always_comb begin
    case (b_quad)
      2'd0: begin
        sn = 16'(b_lo);
        cs = 16'(b_hi);
      end
      2'd1: begin
        sn = 16'(b_hi);
        cs = -$signed(16'(b_lo));
      end
      2'd2: begin
        sn = -$signed(16'(b_lo));
        cs = -$signed(16'(b_hi));
      end
      default: begin
        sn = -$signed(16'(b_hi));
        cs = 16'(b_lo);
      end
    endcase
    dx = 17'(cs) - 17'(held_x);
    dy = 17'(sn) - 17'(held_y);
    adx = dx[16] ? 17'(-dx) : 17'(dx);
    ady = dy[16] ? 17'(-dy) : 17'(dy);
    nx = (adx < {1'b0, cfg.filter_threshold}) ? held_x : cs;
    ny = (ady < {1'b0, cfg.filter_threshold}) ? held_y : sn;
  end

  assign heading.valid = out_valid;
  assign heading.heading_x = held_x;
  assign heading.heading_y = held_y;
  assign heading.vector_changed = changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      out_valid <= 1'b0;
      held_x <= '0;
      held_y <= '0;
    end else begin
      if (pop_valid && a_ready) begin
        phase <= phase + pop_inc;
        a_valid <= 1'b1;
      end else if (b_ready) begin
        a_valid <= 1'b0;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        out_valid <= b_valid;
        if (b_valid) begin
          held_x <= nx;
          held_y <= ny;
        end
      end
    end
    if (a_valid && b_ready) begin
      b_quad <= phase[15:14];
      b_lo <= SIN_TAB[idx_lo];
      b_hi <= SIN_TAB[idx_hi];
    end
    if (b_valid && c_ready) begin
      changed <= (nx != held_x) || (ny != held_y);
    end
  end

endmodule

/* src/joystick_heading_vector_unit.sv */
// Top level of the joystick heading vector unit: configuration registers and
// the front end, queue and back end. Depends on jhv_pkg, jhv_sample_if,
// jhv_heading_if, jhv_front, jhv_queue and jhv_back.
//
// Usage: raw axis samples arrive on the sample channel, one request per
// sample, and each produces exactly one request on the heading channel that
// carries the held Q1.14 cosine and sine and a change flag. The write port
// (cfg_we, cfg_index, cfg_data) sets the midpoint, the signed step scale and
// the filter threshold; write it only while no sample is in flight.
// Throughput is one sample per cycle while the heading receiver is ready.
// A sample passes a multiply register, a four-entry queue, the phase
// accumulator and a registered sine table lookup, then the filter that
// loads the held vector into the output register.
// Reset clears the phase and the held vector to zero, loads the register
// reset values and empties the pipeline. When the receiver stalls, the back
// end stages fill, then the queue, and only then does the sample channel
// drop ready; no request is lost or repeated.
`timescale 1ns / 1ps

module joystick_heading_vector_unit
  import jhv_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  jhv_sample_if.sink    sample,
  jhv_heading_if.source heading,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  cfg_t        cfg;
  logic        push_valid;
  logic        push_ready;
  logic [15:0] push_inc;
  logic        pop_valid;
  logic        pop_ready;
  logic [15:0] pop_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis_mid <= 16'd32768;
      cfg.step_scale <= '0;
      cfg.filter_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AXIS_MID: begin
          cfg.axis_mid <= cfg_data[15:0];
        end
        REG_STEP_SCALE: begin
          cfg.step_scale <= $signed(cfg_data);
        end
        REG_FILTER_THRESHOLD: begin
          cfg.filter_threshold <= cfg_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  jhv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_inc   (push_inc)
  );

  jhv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_inc   (push_inc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_inc    (pop_inc)
  );

  jhv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_inc   (pop_inc),
    .heading   (heading)
  );

endmodule

/* test/tb_joystick_heading_vector_unit.sv */
// Testbench for joystick_heading_vector_unit: a table of directed samples and then
// random phases under several register settings, each result checked in order.
// Depends on jhv_pkg, jhv_sample_if, jhv_heading_if and the unit itself.
`timescale 1ns / 1ps

module tb_joystick_heading_vector_unit;
  import jhv_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_SAMPLES = 100;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               changed;
  } heading_t;

  typedef struct packed {
    logic [15:0] mid;
    logic [31:0] scale;
    logic [15:0] thr;
    logic [15:0] sample;
    logic        known;
    heading_t    want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{16'd32768, 32'h0000_0000, 16'd0,     16'h0000, 1'b1, '{16'sd16384, 16'sd0, 1'b1}},
    '{16'd32768, 32'h0000_0000, 16'd0,     16'hFFFF, 1'b1, '{16'sd16384, 16'sd0, 1'b0}},
    '{16'd0,     32'h4000_0000, 16'd0,     16'h0001, 1'b1, '{16'sd0, 16'sd16384, 1'b1}},
    '{16'd0,     32'h4000_0000, 16'd0,     16'h0001, 1'b1, '{-16'sd16384, 16'sd0, 1'b1}},
    '{16'd0,     32'h4000_0000, 16'd0,     16'h0001, 1'b1, '{16'sd0, -16'sd16384, 1'b1}},
    '{16'd0,     32'h4000_0000, 16'd0,     16'h0001, 1'b1, '{16'sd16384, 16'sd0, 1'b1}},
    '{16'd0,     32'h4000_0000, 16'd0,     16'h0000, 1'b1, '{16'sd16384, 16'sd0, 1'b0}},
    '{16'd65535, 32'h8000_0000, 16'd0,     16'h0000, 1'b1, '{-16'sd16384, 16'sd0, 1'b1}},
    '{16'd65535, 32'h8000_0000, 16'd0,     16'hFFFF, 1'b1, '{-16'sd16384, 16'sd0, 1'b0}},
    '{16'd0,     32'h4000_0000, 16'd32768, 16'h0002, 1'b1, '{16'sd16384, 16'sd0, 1'b1}},
    '{16'd0,     32'h4000_0000, 16'd32768, 16'h0001, 1'b1, '{16'sd16384, 16'sd0, 1'b0}},
    '{16'd0,     32'h4000_0000, 16'd65535, 16'h0002, 1'b1, '{16'sd16384, 16'sd0, 1'b0}},
    '{16'd0,     32'h7FFF_FFFF, 16'd0,     16'hFFFF, 1'b0, '0},
    '{16'd65535, 32'h7FFF_FFFF, 16'd0,     16'h0000, 1'b0, '0},
    '{16'd32768, 32'h0000_0001, 16'd0,     16'h8001, 1'b0, '0},
    '{16'd32768, 32'hFFFF_FFFF, 16'd0,     16'h8001, 1'b0, '0},
    '{16'd32768, 32'h0001_0000, 16'd100,   16'h8100, 1'b0, '0},
    '{16'd32768, 32'h0001_0000, 16'd100,   16'h8050, 1'b0, '0},
    '{16'd32768, 32'h0001_0000, 16'd100,   16'h7F00, 1'b0, '0},
    '{16'd32768, 32'hFFFF_0000, 16'd5,     16'h8123, 1'b0, '0},
    '{16'd12345, 32'h0003_2100, 16'd16384, 16'h0000, 1'b0, '0},
    '{16'd0,     32'h8000_0000, 16'd1,     16'hFFFF, 1'b0, '0}
  };

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  jhv_sample_if  sample_bus();
  jhv_heading_if heading_bus();

  joystick_heading_vector_unit dut (
    .clk(clk),
    .rst(rst),
    .sample(sample_bus),
    .heading(heading_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cfg_t        shadow_cfg;
  logic [15:0] phase;
  int          held_x;
  int          held_y;
  int unsigned quarter_sine [QTR_SIZE + 1];
  heading_t    expected_heading_q[$];
  int          mismatches;
  bit          calm;

  // Quarter-wave sine in Q1.14 from a Taylor series evaluated in Q2.30.
  function automatic int unsigned quarter_sine_value(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] r;
    longint      acc;
    x = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    term = x;
    acc = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = ($unsigned(acc) + 64'd32768) >> 16;
    if (r > 64'd16384) begin
      r = 64'd16384;
    end
    return 32'(r);
  endfunction

  function automatic heading_t predict_heading(logic [15:0] s);
    logic signed [16:0] diff;
    logic signed [63:0] product;
    int unsigned        idx;
    int                 cs;
    int                 sn;
    int                 nx;
    int                 ny;
    int                 dx;
    int                 dy;
    heading_t           res;
    diff = $signed({1'b0, s}) - $signed({1'b0, shadow_cfg.axis_mid});
    product = 64'(diff) * 64'(shadow_cfg.step_scale);
    phase = phase + product[31:16];
    idx = 32'(phase[13 -: SINE_TABLE_BITS]);
    case (phase[15:14])
      2'd0: begin
        sn = quarter_sine[idx];
        cs = quarter_sine[QTR_SIZE - idx];
      end
      2'd1: begin
        sn = quarter_sine[QTR_SIZE - idx];
        cs = -int'(quarter_sine[idx]);
      end
      2'd2: begin
        sn = -int'(quarter_sine[idx]);
        cs = -int'(quarter_sine[QTR_SIZE - idx]);
      end
      default: begin
        sn = -int'(quarter_sine[QTR_SIZE - idx]);
        cs = quarter_sine[idx];
      end
    endcase
    dx = cs - held_x;
    dy = sn - held_y;
    if (dx < 0) begin
      dx = -dx;
    end
    if (dy < 0) begin
      dy = -dy;
    end
    nx = (dx < int'(shadow_cfg.filter_threshold)) ? held_x : cs;
    ny = (dy < int'(shadow_cfg.filter_threshold)) ? held_y : sn;
    res.changed = (nx != held_x) || (ny != held_y);
    held_x = nx;
    held_y = ny;
    res.x = 16'(held_x);
    res.y = 16'(held_y);
    return res;
  endfunction

  task automatic send_sample(logic [15:0] s, logic known, heading_t want);
    heading_t predicted;
    @(negedge clk);
    sample_bus.valid <= 1'b1;
    sample_bus.axis_sample <= s;
    do @(posedge clk); while (!sample_bus.ready);
    predicted = predict_heading(s);
    expected_heading_q.push_back(known ? want : predicted);
  endtask

  task automatic hold_samples(int unsigned cycles);
    @(negedge clk);
    sample_bus.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_headings();
    hold_samples(1);
    while (expected_heading_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_AXIS_MID:         shadow_cfg.axis_mid = data[15:0];
      REG_STEP_SCALE:       shadow_cfg.step_scale = data;
      REG_FILTER_THRESHOLD: shadow_cfg.filter_threshold = data[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] mid, logic [31:0] scale, logic [15:0] thr);
    drain_headings();
    write_reg(REG_NONE, $urandom());
    write_reg(REG_AXIS_MID, {16'($urandom_range(0, 65535)), mid});
    write_reg(REG_STEP_SCALE, scale);
    write_reg(REG_FILTER_THRESHOLD, {16'($urandom_range(0, 65535)), thr});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_settings(output logic [15:0] mid, output logic [31:0] scale,
                               output logic [15:0] thr);
    logic [31:0] mag;
    case ($urandom_range(0, 3))
      0: mid = 16'd0;
      1: mid = 16'd65535;
      2: mid = 16'd32768;
      default: mid = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 5))
      0: scale = 32'h8000_0000;
      1: scale = 32'h7FFF_FFFF;
      2: scale = $urandom();
      default: begin
        mag = $urandom_range(1, 1 << $urandom_range(4, 20));
        scale = $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
    case ($urandom_range(0, 5))
      0: thr = 16'd0;
      1: thr = 16'd65535;
      2: thr = 16'd32768;
      3: thr = 16'($urandom_range(0, 32768));
      default: thr = 16'($urandom_range(0, 400));
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned run_len;
    heading_bus.ready = 1'b0;
    forever begin
      run_len = $urandom_range(1, 40);
      repeat (run_len) begin
        @(negedge clk);
        heading_bus.ready <= 1'b1;
      end
      if (!calm) begin
        repeat ($urandom_range(1, 13)) begin
          @(negedge clk);
          heading_bus.ready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    heading_t want;
    if (!rst && heading_bus.valid && heading_bus.ready) begin
      if (expected_heading_q.size() == 0) begin
        $error("heading request with no expected heading waiting");
        mismatches++;
      end else begin
        want = expected_heading_q.pop_front();
        if (heading_bus.heading_x !== want.x) begin
          $error("heading_x: expected %0d, got %0d", want.x, heading_bus.heading_x);
          mismatches++;
        end
        if (heading_bus.heading_y !== want.y) begin
          $error("heading_y: expected %0d, got %0d", want.y, heading_bus.heading_y);
          mismatches++;
        end
        if (heading_bus.vector_changed !== want.changed) begin
          $error("vector_changed: expected %0d, got %0d", want.changed,
                 heading_bus.vector_changed);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [15:0] mid;
    logic [31:0] scale;
    logic [15:0] thr;
    logic [15:0] s;
    stim_row_t   row;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_AXIS_MID;
    cfg_data = '0;
    sample_bus.valid = 1'b0;
    sample_bus.axis_sample = '0;
    mismatches = 0;
    calm = 1'b0;
    for (int k = 0; k <= QTR_SIZE; k++) begin
      quarter_sine[k] = quarter_sine_value(k);
    end
    shadow_cfg.axis_mid = 16'd32768;
    shadow_cfg.step_scale = '0;
    shadow_cfg.filter_threshold = '0;
    phase = '0;
    held_x = 0;
    held_y = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.mid != shadow_cfg.axis_mid || row.scale != shadow_cfg.step_scale ||
          row.thr != shadow_cfg.filter_threshold) begin
        apply_settings(row.mid, row.scale, row.thr);
      end
      send_sample(row.sample, row.known, row.want);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm = (ph == RANDOM_PHASES - 1);
      pick_settings(mid, scale, thr);
      apply_settings(mid, scale, thr);
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        if (ph == 2 && i == PHASE_SAMPLES / 2) begin
          drain_headings();
        end else if (!calm && $urandom_range(0, 3) == 0) begin
          hold_samples($urandom_range(1, 13));
        end
        if ($urandom_range(0, 2) == 0) begin
          s = 16'($urandom_range(0, 65535));
        end else begin
          s = shadow_cfg.axis_mid + 16'($urandom_range(0, 4000) - 2000);
        end
        send_sample(s, 1'b0, '0);
      end
    end

    drain_headings();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
